>>> sv/b2ss_pkg.sv
// Shared types, constants and the segment table for the binary to seven-segment encoder.
`timescale 1ns / 1ps
`default_nettype none
package b2ss_pkg;

  localparam int unsigned ValueW    = 16;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 4;
  localparam int unsigned BcdW      = DigitW * NumDigits;
  localparam int unsigned AccW      = BcdW + ValueW;
  localparam int unsigned NumSteps  = ValueW;
  localparam int unsigned SegW      = 8;

  localparam logic [ValueW-1:0] SatMax    = 16'd9999;
  localparam logic [DigitW-1:0] AddLimit  = 4'd5;
  localparam logic [DigitW-1:0] AddAdjust = 4'd3;
  localparam logic [SegW-1:0]   PointBit  = 8'h80;

  // One item moving along the conversion chain.
  typedef struct packed {
    logic [AccW-1:0] acc;
    logic            point;
  } b2ss_item_t;

  // Bit 0 is the top segment, then clockwise, bit 6 is the middle one.
  function automatic logic [SegW-1:0] seg_encode(input logic [DigitW-1:0] digit);
    logic [SegW-1:0] seg;
    unique case (digit)
      4'h0: seg = 8'h3F;
      4'h1: seg = 8'h06;
      4'h2: seg = 8'h5B;
      4'h3: seg = 8'h4F;
      4'h4: seg = 8'h66;
      4'h5: seg = 8'h6D;
      4'h6: seg = 8'h7D;
      4'h7: seg = 8'h07;
      4'h8: seg = 8'h7F;
      4'h9: seg = 8'h6F;
      4'hA: seg = 8'h5F;
      4'hB: seg = 8'h7C;
      4'hC: seg = 8'h58;
      4'hD: seg = 8'h5E;
      4'hE: seg = 8'h7B;
      default: seg = 8'h71;
    endcase
    return seg;
  endfunction

endpackage
`default_nettype wire

>>> sv/binary_to_seven_segment_display.sv
// Top level of the binary to seven-segment encoder: saturation, dabble chain and output stage.
`timescale 1ns / 1ps
`default_nettype none
// A request carries a signed 16-bit value and a decimal-point flag; negative values and
// values above 9999 show as 9999. The value runs through a chain of 16 double-dabble cells,
// one shift-and-add-3 step per cell, and an output register that maps the digits to segment
// bytes; a request passes through the cells in order, then the output register. While the
// output is not stalled, every cell holds one request and hands it on each cycle, so a new
// request is taken every cycle; on a stall, empty cells still fill up before the input stops.
module binary_to_seven_segment_display (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // [15:0] value, [16] show_point, [23:17] zero
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [47:0] m_tdata    // [7:0] seg_thousands, [15:8] seg_hundreds,
                                 // [23:16] seg_tens, [31:24] seg_units, [47:32] bcd_word
);
  import b2ss_pkg::*;

  logic [ValueW-1:0] value;
  logic [ValueW-1:0] sat_value;
  logic              show_point;

  logic       valid_c [NumSteps+1];
  logic       ready_c [NumSteps+1];
  b2ss_item_t item_c  [NumSteps+1];

  logic [SegW-1:0] seg_thousands;
  logic [SegW-1:0] seg_hundreds;
  logic [SegW-1:0] seg_tens;
  logic [SegW-1:0] seg_units;
  logic [BcdW-1:0] bcd_word;

  assign value      = s_tdata[ValueW-1:0];
  assign show_point = s_tdata[ValueW];

  // A negative value reads as a large unsigned number and so saturates as well.
  assign sat_value = (value[ValueW-1] || value > SatMax) ? SatMax : value;

  assign valid_c[0]      = s_tvalid;
  assign s_tready        = ready_c[0];
  assign item_c[0].acc   = {{BcdW{1'b0}}, sat_value};
  assign item_c[0].point = show_point;

  for (genvar i = 0; i < NumSteps; i++) begin : g_cell
    b2ss_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid_c[i]),
      .in_ready  (ready_c[i]),
      .in_item   (item_c[i]),
      .out_valid (valid_c[i+1]),
      .out_ready (ready_c[i+1]),
      .out_item  (item_c[i+1])
    );
  end

  b2ss_out u_out (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (valid_c[NumSteps]),
    .in_ready      (ready_c[NumSteps]),
    .in_item       (item_c[NumSteps]),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .seg_thousands (seg_thousands),
    .seg_hundreds  (seg_hundreds),
    .seg_tens      (seg_tens),
    .seg_units     (seg_units),
    .bcd_word      (bcd_word)
  );

  assign m_tdata = {bcd_word, seg_units, seg_tens, seg_hundreds, seg_thousands};

`ifndef SYNTHESIS
  // Saturation keeps every delivered digit a valid decimal digit.
  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[35:32] < 4'd10) && (m_tdata[39:36] < 4'd10) &&
                 (m_tdata[43:40] < 4'd10) && (m_tdata[47:44] < 4'd10))
    else $error("BCD digit out of range");

  // Only the hundreds digit may carry the decimal point.
  a_point_place: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !m_tdata[7] && !m_tdata[23] && !m_tdata[31])
    else $error("decimal point on wrong digit");

  // With the output empty, nothing in the chain can block a new request.
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output is empty");

  // An accepted request always leaves the first cell occupied.
  a_first_cell: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> valid_c[1])
    else $error("accepted request lost in first cell");
`endif

endmodule
`default_nettype wire

>>> sv/b2ss_cell.sv
// One double-dabble step: add 3 to every BCD digit of 5 or more, then shift left by one.
`timescale 1ns / 1ps
`default_nettype none
module b2ss_cell (
  input  wire                    clk,
  input  wire                    rst,
  input  wire                    in_valid,
  output logic                   in_ready,
  input  b2ss_pkg::b2ss_item_t   in_item,
  output logic                   out_valid,
  input  wire                    out_ready,
  output b2ss_pkg::b2ss_item_t   out_item
);
  import b2ss_pkg::*;

  logic            valid;
  b2ss_item_t      item;
  logic [AccW-1:0] adj;

  // Digits never exceed 9 here, so each add stays inside its own nibble.
  always_comb begin
    adj = in_item.acc;
    for (int d = 0; d < NumDigits; d++) begin
      if (in_item.acc[ValueW + DigitW*d +: DigitW] >= AddLimit) begin
        adj[ValueW + DigitW*d +: DigitW] = in_item.acc[ValueW + DigitW*d +: DigitW] + AddAdjust;
      end
    end
  end

  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.acc   <= {adj[AccW-2:0], 1'b0};
      item.point <= in_item.point;
    end
  end

endmodule
`default_nettype wire

>>> sv/b2ss_out.sv
// Output register: maps the four BCD digits to segment bytes and holds the result.
`timescale 1ns / 1ps
`default_nettype none
module b2ss_out (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        in_valid,
  output logic                       in_ready,
  input  b2ss_pkg::b2ss_item_t       in_item,
  output logic                       out_valid,
  input  wire                        out_ready,
  output logic [b2ss_pkg::SegW-1:0]  seg_thousands,
  output logic [b2ss_pkg::SegW-1:0]  seg_hundreds,
  output logic [b2ss_pkg::SegW-1:0]  seg_tens,
  output logic [b2ss_pkg::SegW-1:0]  seg_units,
  output logic [b2ss_pkg::BcdW-1:0]  bcd_word
);
  import b2ss_pkg::*;

  logic            valid;
  logic [BcdW-1:0] bcd;

  assign bcd       = in_item.acc[AccW-1 -: BcdW];
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      seg_thousands <= seg_encode(bcd[3*DigitW +: DigitW]);
      seg_hundreds  <= seg_encode(bcd[2*DigitW +: DigitW]) | (in_item.point ? PointBit : '0);
      seg_tens      <= seg_encode(bcd[DigitW +: DigitW]);
      seg_units     <= seg_encode(bcd[0 +: DigitW]);
      bcd_word      <= bcd;
    end
  end

endmodule
`default_nettype wire
